// ----- rtl/pln_pkg.sv -----
// Shared constants, types and command/status bundles for the path normaliser.
package pln_pkg;

    localparam int DEF_PATH_CAPACITY = 64;
    localparam int DEF_STACK_SLOTS   = 32;

    // Capacity register and every position derived from it.
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic [CAP_W-1:0] MIN_CAP   = 7'd2;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_OUT_CAPACITY = 1'b0;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    typedef struct packed {
        logic take_byte;
        logic take_term;
        logic load_fail;
        logic load_first;
        logic load_byte;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic in_term;
        logic stk_wait;
        logic out_free;
        logic fin_fail;
        logic fin_single;
        logic emit_last;
    } t_stat;

endpackage

// ----- rtl/pln_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pln_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pln_ctrl.sv -----
// Controller state machine: input acceptance, finish decision and result emission.
module pln_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pln_pkg::t_stat i_stat,
    output pln_pkg::t_cmd  o_cmd
);
    import pln_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FINISH,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.stk_wait;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.in_term) begin
                        o_cmd.take_term = 1'b1;
                        n_state         = S_FINISH;
                    end else begin
                        o_cmd.take_byte = 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    if (i_stat.fin_fail) begin
                        o_cmd.load_fail = 1'b1;
                        o_cmd.clear     = 1'b1;
                        n_state         = S_IDLE;
                    end else if (i_stat.fin_single) begin
                        o_cmd.load_first = 1'b1;
                        o_cmd.clear      = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.load_first = 1'b1;
                        n_state          = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                // The store read is issued here; the result register must be free
                // by the time the data arrives.
                if (i_stat.out_free) begin
                    n_state = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                o_cmd.load_byte = 1'b1;
                if (i_stat.emit_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_term_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_term |=> (r_state == S_FINISH))
        else $error("terminator did not lead to the finish state");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_fail, o_cmd.load_first, o_cmd.load_byte}))
        else $error("more than one result load in a cycle");

    a_rd_then_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD) && i_stat.out_free |=> o_cmd.load_byte)
        else $error("store read not followed by a result load");
`endif

endmodule

// ----- rtl/pln_dp.sv -----
// Datapath: path store, component start stack, counters and result register.
module pln_dp #(
    parameter int PATH_CAPACITY = pln_pkg::DEF_PATH_CAPACITY,
    parameter int STACK_SLOTS   = pln_pkg::DEF_STACK_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pln_pkg::CAP_W-1:0]  i_out_capacity,
    input  logic [7:0]                 i_in_char,
    input  pln_pkg::t_cmd              i_cmd,
    output pln_pkg::t_stat             o_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_out_char,
    output logic                       o_out_last,
    output logic                       o_out_failed
);
    import pln_pkg::*;

    localparam int AW_P  = $clog2(PATH_CAPACITY);
    localparam int SA_W  = $clog2(STACK_SLOTS);
    localparam int SC_W  = $clog2(STACK_SLOTS + 1);
    localparam int CNT_W = $clog2(PATH_CAPACITY);
    localparam int SUM_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    logic [SC_W-1:0]  r_stack_count;
    logic [CAP_W-1:0] r_write_pos;
    logic [CNT_W-1:0] r_bytes_seen;
    logic [CNT_W-1:0] r_comp_len;
    logic             r_all_dots;
    logic             r_failed;
    logic             r_stk_wait;
    logic [CAP_W-1:0] r_k;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             r_out_failed;

    logic             is_slash;
    logic             too_long;
    logic             first;
    logic             byte_live;
    logic             do_close;
    logic             fail_in;
    logic             cl_act;
    logic             dot1;
    logic             dot2;
    logic             sep;
    logic [SUM_W-1:0] wp_ext;
    logic [SUM_W-1:0] wp_sum;
    logic [SUM_W-1:0] end_pos;
    logic             push_ok;
    logic             do_pop;
    logic             do_push;
    logic             pop_fail;
    logic             push_fail;
    logic             sep_wr;
    logic             char_wr;
    logic             fail_set;
    logic [CAP_W-1:0] top;
    logic [CAP_W-1:0] pop_pos;
    logic [SC_W-1:0]  sc_m1;
    logic [SUM_W-1:0] k_ext;
    logic             path_we;
    logic [AW_P-1:0]  path_waddr;
    logic [7:0]       path_wdata;
    logic [7:0]       path_rdata;
    logic             out_take;

    assign is_slash  = (i_in_char == CHAR_SLASH);
    assign too_long  = (r_bytes_seen >= CNT_W'(PATH_CAPACITY - 1));
    assign first     = (r_bytes_seen == '0);
    assign byte_live = i_cmd.take_byte && !r_failed && !too_long && !first;

    // The terminator also fails an empty path or a capacity too small for "/".
    assign fail_in  = i_cmd.take_term ? (r_failed || first || (i_out_capacity < MIN_CAP))
                                      : r_failed;
    assign do_close = (byte_live && is_slash) || i_cmd.take_term;
    assign cl_act   = do_close && (r_comp_len != '0) && !fail_in;
    assign dot1     = r_all_dots && (r_comp_len == CNT_W'(1));
    assign dot2     = r_all_dots && (r_comp_len == CNT_W'(2));

    assign sep     = (r_write_pos > CAP_W'(1));
    assign wp_ext  = SUM_W'(r_write_pos);
    assign wp_sum  = wp_ext + SUM_W'(sep);
    assign end_pos = wp_sum + SUM_W'(r_comp_len);
    assign push_ok = (end_pos < SUM_W'(i_out_capacity))
                  && (r_stack_count < SC_W'(STACK_SLOTS));

    assign do_pop    = cl_act && dot2 && (r_stack_count != '0);
    assign pop_fail  = cl_act && dot2 && (r_stack_count == '0);
    assign do_push   = cl_act && !dot1 && !dot2 && push_ok;
    assign push_fail = cl_act && !dot1 && !dot2 && !push_ok;

    assign pop_pos = (top > CAP_W'(1)) ? (top - CAP_W'(1)) : top;
    assign sc_m1   = r_stack_count - SC_W'(1);

    // A component byte lands at the same place a later push would end it.
    assign char_wr = byte_live && !is_slash && (end_pos < SUM_W'(PATH_CAPACITY));
    assign sep_wr  = do_push && sep && (wp_ext < SUM_W'(PATH_CAPACITY));

    assign path_we    = sep_wr || char_wr;
    assign path_waddr = sep_wr ? wp_ext[AW_P-1:0] : end_pos[AW_P-1:0];
    assign path_wdata = sep_wr ? CHAR_SLASH : i_in_char;
    assign k_ext      = SUM_W'(r_k);

    assign fail_set = (i_cmd.take_byte && !r_failed && (too_long || (first && !is_slash)))
                   || (i_cmd.take_term && fail_in) || pop_fail || push_fail;

    pln_ram #(
        .WIDTH (8),
        .DEPTH (PATH_CAPACITY)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_waddr),
        .i_wdata (path_wdata),
        .i_raddr (k_ext[AW_P-1:0]),
        .o_rdata (path_rdata)
    );

    // The read address follows the stack top; the controller holds input off after
    // each push or pop, while stk_wait is set, so that the top is valid again.
    pln_ram #(
        .WIDTH (CAP_W),
        .DEPTH (STACK_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_stack_count[SA_W-1:0]),
        .i_wdata (wp_sum[CAP_W-1:0]),
        .i_raddr (sc_m1[SA_W-1:0]),
        .o_rdata (top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_stack_count <= '0;
            r_write_pos   <= CAP_W'(1);
            r_bytes_seen  <= '0;
            r_comp_len    <= '0;
            r_all_dots    <= 1'b1;
            r_failed      <= 1'b0;
            r_stk_wait    <= 1'b0;
        end else begin
            r_failed   <= r_failed || fail_set;
            r_stk_wait <= do_push || do_pop;
            if (i_cmd.take_byte && !r_failed && !too_long) begin
                r_bytes_seen <= r_bytes_seen + CNT_W'(1);
            end
            if (byte_live && !is_slash) begin
                r_comp_len <= r_comp_len + CNT_W'(1);
                if (i_in_char != CHAR_DOT) begin
                    r_all_dots <= 1'b0;
                end
            end
            if (do_close) begin
                r_comp_len <= '0;
                r_all_dots <= 1'b1;
            end
            if (do_pop) begin
                r_stack_count <= r_stack_count - SC_W'(1);
                r_write_pos   <= pop_pos;
            end
            if (do_push) begin
                r_stack_count <= r_stack_count + SC_W'(1);
                r_write_pos   <= end_pos[CAP_W-1:0];
            end
        end
    end

    assign out_take = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_fail || i_cmd.load_first || i_cmd.load_byte) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fail) begin
            r_out_char   <= CHAR_NUL;
            r_out_last   <= 1'b1;
            r_out_failed <= 1'b1;
        end else if (i_cmd.load_first) begin
            r_out_char   <= CHAR_SLASH;
            r_out_last   <= o_stat.fin_single;
            r_out_failed <= 1'b0;
            r_k          <= CAP_W'(1);
        end else if (i_cmd.load_byte) begin
            r_out_char   <= path_rdata;
            r_out_last   <= o_stat.emit_last;
            r_out_failed <= 1'b0;
            r_k          <= r_k + CAP_W'(1);
        end
    end

    assign o_stat.in_term    = (i_in_char == CHAR_NUL);
    assign o_stat.stk_wait   = r_stk_wait;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.fin_fail   = r_failed || (r_write_pos == '0)
                            || (wp_ext > SUM_W'(PATH_CAPACITY - 1));
    assign o_stat.fin_single = (r_write_pos == CAP_W'(1));
    assign o_stat.emit_last  = ((r_k + CAP_W'(1)) == r_write_pos);

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_out_last   = r_out_last;
    assign o_out_failed = r_out_failed;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stack_count <= SC_W'(STACK_SLOTS))
        else $error("component stack count beyond its slots");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_pos != '0)
        else $error("path length fell to zero");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_push && do_pop) && !(path_we && r_failed && !i_cmd.take_term))
        else $error("conflicting stack update or store write after failure");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_fail || i_cmd.load_first || i_cmd.load_byte) |-> !r_out_valid || out_take)
        else $error("result register overwritten before it was taken");
`endif

endmodule

// ----- rtl/path_lexical_normalizer_core.sv -----
// Top level of the path normaliser: configuration register, controller and datapath.
//
// Usage: an absolute path enters one byte per input beat (i_in_char), a zero
// byte ending it. After a component is pushed or popped by a slash, input ready
// drops while the component start stack read port catches up with the new top.
// On the terminator the block stops taking input and, once the result register
// is free, loads the first result beat: either one failure beat (char 0, last,
// failed) or the normalised path, a byte per beat with last set on the final
// one. The leading slash is loaded directly; later bytes come from the path
// store by a registered store read, then a result register load, each read
// loaded before the next is issued. Input is taken again once the final beat
// sits in the result register, so the next path may start while it waits. A
// stalled receiver simply holds the result register; the block waits. Reset
// (synchronous, active low) empties the block, clears the path state and sets
// out_capacity to 64; there is no clearing pass. out_capacity lies at APB byte
// address 0 and must be written only while the block is idle; nothing enforces it.
module path_lexical_normalizer_core #(
    parameter int PATH_CAPACITY = pln_pkg::DEF_PATH_CAPACITY,
    parameter int STACK_SLOTS   = pln_pkg::DEF_STACK_SLOTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pln_pkg::PADDR_W-1:0] paddr,
    input  logic [pln_pkg::PDATA_W-1:0] pwdata,
    output logic [pln_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_in_char,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_out_char,
    output logic                        o_out_last,
    output logic                        o_out_failed
);
    import pln_pkg::*;

    logic [CAP_W-1:0] r_out_capacity;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OUT_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_out_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? PDATA_W'(r_out_capacity) : '0;

    pln_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pln_dp #(
        .PATH_CAPACITY (PATH_CAPACITY),
        .STACK_SLOTS   (STACK_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_out_capacity (r_out_capacity),
        .i_in_char      (i_in_char),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_out_last     (o_out_last),
        .o_out_failed   (o_out_failed)
    );

`ifndef SYNTHESIS
    a_no_input_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_char == CHAR_NUL)) |=> !o_in_ready)
        else $error("input taken straight after a terminator");

    a_fail_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_failed) |-> (o_out_last && (o_out_char == CHAR_NUL)))
        else $error("failure beat without last or with a non-zero byte");

    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_wr |=> $stable(r_out_capacity))
        else $error("capacity changed without a write");
`endif

endmodule

// ----- verif/pln_checker.sv -----
// Checker for the path normaliser: predicts result beats from accepted input and compares them.
module pln_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pln_pkg::PADDR_W-1:0] paddr,
    input  logic [pln_pkg::PDATA_W-1:0] pwdata,
    input  logic                        pready,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_in_char,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [7:0]                  i_out_char,
    input  logic                        i_out_last,
    input  logic                        i_out_failed,
    output int                          o_errors,
    output int                          o_pending
);
    import pln_pkg::*;

    localparam int PATH_CAP = DEF_PATH_CAPACITY;
    localparam int SLOTS    = DEF_STACK_SLOTS;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       failed;
    } t_beat;

    t_beat            expected_beats[$];
    logic [7:0]       path_mem [PATH_CAP];
    logic [6:0]       seg_starts [SLOTS];
    logic [5:0]       kept_count;
    logic [6:0]       build_len;
    logic [6:0]       bytes_in;
    logic [6:0]       seg_len;
    logic             seg_dots;
    logic             rejected;
    logic [CAP_W-1:0] capacity;
    int               err_count;

    function automatic void clear_path();
        kept_count = '0;
        build_len  = 7'd1;
        bytes_in   = '0;
        seg_len    = '0;
        seg_dots   = 1'b1;
        rejected   = 1'b0;
    endfunction

    // A segment is judged when a slash or the terminator closes it.
    function automatic void close_segment();
        logic [7:0] sep;
        logic [7:0] end_pos;
        if (seg_len != 0 && !rejected) begin
            if (seg_dots && seg_len == 2) begin
                if (kept_count == 0) begin
                    rejected = 1'b1;
                end else begin
                    kept_count = kept_count - 1'b1;
                    build_len  = seg_starts[kept_count % SLOTS];
                    if (build_len > 1) build_len = build_len - 1'b1;
                end
            end else if (!(seg_dots && seg_len == 1)) begin
                sep     = (build_len > 1) ? 8'd1 : 8'd0;
                end_pos = build_len + sep + seg_len;
                if (end_pos >= capacity || kept_count >= SLOTS) begin
                    rejected = 1'b1;
                end else begin
                    seg_starts[kept_count] = build_len + sep;
                    kept_count = kept_count + 1'b1;
                    if (sep != 0 && build_len < PATH_CAP) path_mem[build_len] = CHAR_SLASH;
                    build_len = end_pos[6:0];
                end
            end
        end
        seg_len  = '0;
        seg_dots = 1'b1;
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        logic [7:0] pos;
        if (c != CHAR_NUL) begin
            if (!rejected) begin
                if (bytes_in >= PATH_CAP - 1) begin
                    rejected = 1'b1;
                end else if (bytes_in == 0) begin
                    bytes_in = 7'd1;
                    if (c != CHAR_SLASH) rejected = 1'b1;
                end else begin
                    bytes_in = bytes_in + 1'b1;
                    if (c == CHAR_SLASH) begin
                        close_segment();
                    end else begin
                        pos = build_len + ((build_len > 1) ? 8'd1 : 8'd0) + seg_len;
                        if (pos < PATH_CAP) path_mem[pos] = c;
                        seg_len = seg_len + 1'b1;
                        if (c != CHAR_DOT) seg_dots = 1'b0;
                    end
                end
            end
        end else begin
            if (bytes_in == 0 || capacity < MIN_CAP) rejected = 1'b1;
            close_segment();
            if (rejected || build_len == 0 || build_len > PATH_CAP - 1) begin
                expected_beats.push_back(t_beat'{ch: CHAR_NUL, last: 1'b1, failed: 1'b1});
            end else begin
                for (int k = 0; k < build_len; k++) begin
                    expected_beats.push_back(t_beat'{
                        ch:     (k == 0) ? CHAR_SLASH : path_mem[k],
                        last:   (k + 1 == build_len),
                        failed: 1'b0});
                end
            end
            clear_path();
        end
    endfunction

    function automatic void log_fault(input string what, input t_beat want, input t_beat got);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t: %s: expected char %02h last %0b failed %0b,",
                     $time, what, want.ch, want.last, want.failed,
                     " got char %02h last %0b failed %0b",
                     got.ch, got.last, got.failed);
        end
    endfunction

    initial begin
        err_count = 0;
        capacity  = CAP_RESET;
        clear_path();
    end

    // Result beats are handled before input beats, since a beat accepted on this
    // edge can only cause results on later edges.
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            clear_path();
            capacity = CAP_RESET;
            expected_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_CAPACITY) begin
                capacity = pwdata[CAP_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                got = t_beat'{ch: i_out_char, last: i_out_last, failed: i_out_failed};
                if (expected_beats.size() == 0) begin
                    log_fault("unexpected result beat", '0, got);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last
                            || got.failed !== want.failed) begin
                        log_fault("result mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_char(i_in_char);
        end
        o_errors  <= err_count;
        o_pending <= expected_beats.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the path normaliser: clock, reset, stimulus, configuration and verdict.
module tb_top;
    import pln_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_in_char;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [7:0]           o_out_char;
    logic                 o_out_last;
    logic                 o_out_failed;

    int         fault_count;
    int         pending_beats;
    int         send_gap_pct;
    int         stall_pct;
    int         phase_bytes;
    int         idle_cycles;
    logic [7:0] path_bytes[$];
    int         phase_caps[8] = '{64, 0, 33, 1, 2, 9, 64, 17};

    path_lexical_normalizer_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_char    (i_in_char),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_char   (o_out_char),
        .o_out_last   (o_out_last),
        .o_out_failed (o_out_failed)
    );

    pln_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_char    (i_in_char),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_char   (o_out_char),
        .i_out_last   (o_out_last),
        .i_out_failed (o_out_failed),
        .o_errors     (fault_count),
        .o_pending    (pending_beats)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_byte(input logic [7:0] b);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_path();
        foreach (path_bytes[i]) push_byte(path_bytes[i]);
        phase_bytes += path_bytes.size();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) path_bytes.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        path_bytes.delete();
        add_text(s);
        path_bytes.push_back(CHAR_NUL);
        send_path();
    endtask

    // A slash followed by n bytes that are neither slash nor terminator.
    task automatic build_long_path(input int n);
        logic [7:0] b;
        path_bytes.delete();
        path_bytes.push_back(CHAR_SLASH);
        repeat (n) begin
            b = 8'($urandom_range(1, 255));
            if (b == CHAR_SLASH) b = 8'h7A;
            path_bytes.push_back(b);
        end
        path_bytes.push_back(CHAR_NUL);
    endtask

    task automatic build_random_path();
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // Noise: arbitrary bytes, possibly empty or without a leading slash.
            path_bytes.delete();
            repeat ($urandom_range(0, 5)) path_bytes.push_back(8'($urandom_range(1, 255)));
            path_bytes.push_back(CHAR_NUL);
        end else begin
            path_bytes.delete();
            path_bytes.push_back(CHAR_SLASH);
            for (int i = 0; i < $urandom_range(0, 5); i++) begin
                if (i > 0) path_bytes.push_back(CHAR_SLASH);
                repeat ($urandom_range(0, 2)) path_bytes.push_back(CHAR_SLASH);
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    add_text(".");
                end else if (pick < 35) begin
                    add_text("..");
                end else if (pick < 40) begin
                    add_text("...");
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 55) begin
                            path_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
                        end else if (pick < 70) begin
                            path_bytes.push_back(CHAR_DOT);
                        end else begin
                            path_bytes.push_back(8'($urandom_range(1, 255)));
                        end
                    end
                end
            end
            if ($urandom_range(0, 1)) path_bytes.push_back(CHAR_SLASH);
            path_bytes.push_back(CHAR_NUL);
        end
    endtask

    // Waits until every predicted beat has arrived, then adds a settling margin.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_beats != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_OUT_CAPACITY, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_in_char    = '0;
        i_out_ready  = 1'b1;
        send_gap_pct = 0;
        stall_pct    = 0;
        phase_bytes  = 0;
        idle_cycles  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed paths at the reset capacity of 64.
        send_text("");
        send_text("x");
        send_text("/..");
        path_bytes.delete();
        add_text("//a/./b/../");
        path_bytes.push_back(8'h01);
        path_bytes.push_back(8'hFF);
        path_bytes.push_back(CHAR_NUL);
        send_path();
        // The smallest usable capacity holds the root only.
        write_capacity(2);
        send_text("/");
        send_text("/a");
        write_capacity(1);
        send_text("/");

        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 55; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 55; end
                default: begin send_gap_pct = 29; stall_pct = 29; end
            endcase
            phase_bytes = 0;
            // A path one byte longer than the store accepts.
            if (p == 6) begin
                build_long_path(63);
                send_path();
            end
            while (phase_bytes == 0) begin
                build_random_path();
                send_path();
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (fault_count == 0 && pending_beats == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pln_pkg.sv
rtl/pln_ram.sv
rtl/pln_ctrl.sv
rtl/pln_dp.sv
rtl/path_lexical_normalizer_core.sv
verif/pln_checker.sv
verif/tb_top.sv
